// ----- hdl/dbbm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbbm_pkg: shared constants for the DMA block buffer manager
// Request codes, the default pool size and the overrun counter limit.
// ----------------------------------------------------------------------------
package dbbm_pkg;

	localparam int BUFFERS_DEF = 8;

	localparam logic [2:0] REQ_START    = 3'd0;
	localparam logic [2:0] REQ_STOP     = 3'd1;
	localparam logic [2:0] REQ_DONE     = 3'd2;
	localparam logic [2:0] REQ_POP      = 3'd3;
	localparam logic [2:0] REQ_RELEASE  = 3'd4;
	localparam logic [2:0] REQ_TAKE_OVR = 3'd5;

	localparam logic [31:0] OVR_MAX = 32'hFFFF_FFFF;

endpackage

// ----- hdl/dbbm_ram.sv -----
// ----------------------------------------------------------------------------
// dbbm_ram: ring storage with a registered read port
// One write port and one read port; a write to the address being read in
// the same cycle is forwarded into the read register.
// ----------------------------------------------------------------------------
module dbbm_ram #(
	parameter int DEPTH = 8,
	parameter int W     = 3
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/dma_block_buffer_manager_unit.sv -----
// ----------------------------------------------------------------------------
// dma_block_buffer_manager_unit: buffer pool manager for a DMA-fed converter
// A request passes through the input stage and then the result register.
// Throughput: one request per cycle while results are taken; the ring read
// registers are refreshed from the next-state tail pointers so every request
// finishes in one pass. Reset: arst_n clears all control state at once; ring
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module dma_block_buffer_manager_unit #(
	parameter int BUFFERS = dbbm_pkg::BUFFERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  release_index,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        accepted,
	output logic [2:0]  block_index,
	output logic        overrun_seen,
	output logic [31:0] overrun_total,
	output logic [2:0]  current_buffer,
	output logic [2:0]  next_buffer,
	output logic        next_valid,
	output logic        fill_stalled,
	output logic        is_running,
	output logic        load_current,
	output logic        load_next
);

	import dbbm_pkg::*;

	localparam int PW = $clog2(BUFFERS);
	localparam logic [PW-1:0] LAST_POS = PW'(BUFFERS - 1);
	localparam logic [PW-1:0] INIT_END = PW'(BUFFERS - 2);

	function automatic logic [PW-1:0] ring_nxt(input logic [PW-1:0] p);
		return (p == LAST_POS) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [2:0] buf3(input logic [PW-1:0] b);
		logic [PW+2:0] e;
		e = {3'b000, b};
		return e[2:0];
	endfunction

	// Input stage.
	logic          valid_s1;
	logic [2:0]    req_type_s1;
	logic [7:0]    release_index_s1;
	logic          advance;

	// Pool state.
	logic [PW-1:0] done_head_q, done_tail_q, free_head_q, free_tail_q;
	logic [PW-1:0] cur_q, nxt_q, init_lo_q;
	logic          nxt_valid_q, stall_q, run_q, ovr_flag_q;
	logic [31:0]   ovr_cnt_q;

	// Next state.
	logic [PW-1:0] n_done_head, n_done_tail, n_free_head, n_free_tail;
	logic [PW-1:0] n_cur, n_nxt, n_init_lo;
	logic          n_nxt_valid, n_stall, n_run, n_ovr_flag;
	logic [31:0]   n_ovr_cnt;
	logic          n_accepted, n_seen, n_pc, n_pn;
	logic [PW-1:0] n_blk;

	// Ring access.
	logic          done_we, free_we;
	logic [PW-1:0] done_wdata, free_wdata;
	logic [PW-1:0] done_rd, free_rd0, free_rd1;
	logic [PW-1:0] free_raddr1;

	// Step scratch.
	logic          do_prime, ovr, queued, pop_ok;
	logic [PW-1:0] finished, rel_idx, fp0, fp1, fv0, fv1;
	logic [1:0]    npops;

	// Result register.
	logic          rsp_valid_q;
	logic          accepted_q, seen_q, nv_q, stall_o_q, run_o_q, pc_q, pn_q;
	logic [2:0]    blk_q, cur_o_q, nxt_o_q;
	logic [31:0]   total_q;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_s1      <= req_type;
			release_index_s1 <= release_index;
		end
	end

	assign rel_idx = release_index_s1[PW-1:0];
	assign fp0     = free_tail_q;
	assign fp1     = ring_nxt(free_tail_q);

	// Entries written by start are not stored; positions from init_lo_q up to
	// the end of that range still hold their start value, position plus two.
	always_comb begin
		if (queued && (fp0 == free_head_q)) begin
			fv0 = rel_idx;
		end else if ((fp0 >= init_lo_q) && (fp0 < INIT_END)) begin
			fv0 = fp0 + PW'(2);
		end else begin
			fv0 = free_rd0;
		end
		if (queued && (fp1 == free_head_q)) begin
			fv1 = rel_idx;
		end else if ((fp1 >= init_lo_q) && (fp1 < INIT_END)) begin
			fv1 = fp1 + PW'(2);
		end else begin
			fv1 = free_rd1;
		end
	end

	always_comb begin
		n_done_head = done_head_q;
		n_done_tail = done_tail_q;
		n_free_head = free_head_q;
		n_free_tail = free_tail_q;
		n_cur       = cur_q;
		n_nxt       = nxt_q;
		n_init_lo   = init_lo_q;
		n_nxt_valid = nxt_valid_q;
		n_stall     = stall_q;
		n_run       = run_q;
		n_ovr_flag  = ovr_flag_q;
		n_ovr_cnt   = ovr_cnt_q;
		n_accepted  = 1'b0;
		n_seen      = 1'b0;
		n_pc        = 1'b0;
		n_pn        = 1'b0;
		n_blk       = '0;
		done_we     = 1'b0;
		done_wdata  = cur_q;
		free_we     = 1'b0;
		free_wdata  = rel_idx;
		do_prime    = 1'b0;
		ovr         = 1'b0;
		queued      = 1'b0;
		pop_ok      = 1'b1;
		finished    = cur_q;
		npops       = 2'd0;

		unique case (req_type_s1)
			REQ_START: begin
				n_accepted = 1'b1;
				if (!run_q) begin
					n_ovr_flag  = 1'b0;
					n_ovr_cnt   = '0;
					n_run       = 1'b1;
					n_cur       = '0;
					n_nxt       = PW'(1);
					n_nxt_valid = 1'b1;
					n_stall     = 1'b0;
					n_done_head = '0;
					n_done_tail = '0;
					n_free_head = INIT_END;
					n_free_tail = '0;
					n_init_lo   = '0;
					n_pc        = 1'b1;
					n_pn        = 1'b1;
				end
			end
			REQ_STOP: begin
				n_run = 1'b0;
			end
			REQ_DONE: begin
				if (run_q && !stall_q) begin
					if (nxt_valid_q) begin
						n_cur       = nxt_q;
						n_nxt_valid = 1'b0;
					end else begin
						n_stall = 1'b1;
						ovr     = 1'b1;
					end
					if (ring_nxt(done_head_q) != done_tail_q) begin
						done_we     = 1'b1;
						n_done_head = ring_nxt(done_head_q);
					end else begin
						// The completed ring is full: keep the block in the DMA.
						ovr = 1'b1;
						if (n_stall) begin
							n_cur   = finished;
							n_stall = 1'b0;
							n_pc    = 1'b1;
						end else if (!n_nxt_valid) begin
							n_nxt       = finished;
							n_nxt_valid = 1'b1;
							n_pn        = 1'b1;
						end
					end
					do_prime = 1'b1;
				end
			end
			REQ_POP: begin
				if (done_head_q != done_tail_q) begin
					n_blk       = done_rd;
					n_done_tail = ring_nxt(done_tail_q);
					n_accepted  = 1'b1;
				end
			end
			REQ_RELEASE: begin
				if (release_index_s1 < 8'(BUFFERS)) begin
					if (ring_nxt(free_head_q) != free_tail_q) begin
						queued      = 1'b1;
						free_we     = 1'b1;
						n_free_head = ring_nxt(free_head_q);
						if ((free_head_q == init_lo_q) && (init_lo_q < INIT_END)) begin
							n_init_lo = init_lo_q + PW'(1);
						end
					end else begin
						ovr = 1'b1;
					end
					do_prime = 1'b1;
				end
			end
			REQ_TAKE_OVR: begin
				n_seen     = ovr_flag_q;
				n_ovr_flag = 1'b0;
			end
			default: begin
			end
		endcase

		if (ovr) begin
			n_ovr_flag = 1'b1;
			if (ovr_cnt_q != OVR_MAX) begin
				n_ovr_cnt = ovr_cnt_q + 32'd1;
			end
		end

		// Refill the DMA slots from the free ring, at most two pops.
		if (do_prime && n_run) begin
			if (n_stall) begin
				if (n_free_head == n_free_tail) begin
					pop_ok = 1'b0;
				end else begin
					n_cur       = fv0;
					n_stall     = 1'b0;
					n_pc        = 1'b1;
					n_free_tail = ring_nxt(n_free_tail);
					npops       = 2'd1;
				end
			end
			if (pop_ok && !n_nxt_valid && (n_free_head != n_free_tail)) begin
				n_nxt       = (npops == 2'd0) ? fv0 : fv1;
				n_nxt_valid = 1'b1;
				n_pn        = 1'b1;
				n_free_tail = ring_nxt(n_free_tail);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_head_q <= '0;
			done_tail_q <= '0;
			free_head_q <= '0;
			free_tail_q <= '0;
			cur_q       <= '0;
			nxt_q       <= PW'(1);
			init_lo_q   <= INIT_END;
			nxt_valid_q <= 1'b0;
			stall_q     <= 1'b0;
			run_q       <= 1'b0;
			ovr_flag_q  <= 1'b0;
			ovr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				done_head_q <= n_done_head;
				done_tail_q <= n_done_tail;
				free_head_q <= n_free_head;
				free_tail_q <= n_free_tail;
				cur_q       <= n_cur;
				nxt_q       <= n_nxt;
				init_lo_q   <= n_init_lo;
				nxt_valid_q <= n_nxt_valid;
				stall_q     <= n_stall;
				run_q       <= n_run;
				ovr_flag_q  <= n_ovr_flag;
				ovr_cnt_q   <= n_ovr_cnt;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q <= n_accepted;
			blk_q      <= buf3(n_blk);
			seen_q     <= n_seen;
			total_q    <= n_ovr_cnt;
			cur_o_q    <= buf3(n_cur);
			nxt_o_q    <= buf3(n_nxt);
			nv_q       <= n_nxt_valid;
			stall_o_q  <= n_stall;
			run_o_q    <= n_run;
			pc_q       <= n_pc;
			pn_q       <= n_pn;
		end
	end

	// The read registers follow the tail pointers as they will be after this
	// cycle, so the head entry of each ring is ready for the next transaction.
	logic [PW-1:0] done_raddr, free_raddr0;
	assign done_raddr  = advance ? n_done_tail : done_tail_q;
	assign free_raddr0 = advance ? n_free_tail : free_tail_q;
	assign free_raddr1 = ring_nxt(free_raddr0);

	dbbm_ram #(.DEPTH(BUFFERS), .W(PW)) u_done_ram (
		.clk   (clk),
		.we    (advance && done_we),
		.waddr (done_head_q),
		.wdata (done_wdata),
		.raddr (done_raddr),
		.rdata (done_rd)
	);

	// The free ring is kept twice so that two entries can be read at once.
	dbbm_ram #(.DEPTH(BUFFERS), .W(PW)) u_free_ram0 (
		.clk   (clk),
		.we    (advance && free_we),
		.waddr (free_head_q),
		.wdata (free_wdata),
		.raddr (free_raddr0),
		.rdata (free_rd0)
	);

	dbbm_ram #(.DEPTH(BUFFERS), .W(PW)) u_free_ram1 (
		.clk   (clk),
		.we    (advance && free_we),
		.waddr (free_head_q),
		.wdata (free_wdata),
		.raddr (free_raddr1),
		.rdata (free_rd1)
	);

	assign rsp_valid      = rsp_valid_q;
	assign accepted       = accepted_q;
	assign block_index    = blk_q;
	assign overrun_seen   = seen_q;
	assign overrun_total  = total_q;
	assign current_buffer = cur_o_q;
	assign next_buffer    = nxt_o_q;
	assign next_valid     = nv_q;
	assign fill_stalled   = stall_o_q;
	assign is_running     = run_o_q;
	assign load_current   = pc_q;
	assign load_next      = pn_q;

`ifndef ASSERT_OFF
	a_stall_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		stall_q |-> !nxt_valid_q)
		else $error("stalled DMA with a queued next buffer");

	a_load_clears_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && pc_q |-> !stall_o_q)
		else $error("current pointer load reported while stalled");

	a_load_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (pc_q || pn_q) |-> run_o_q)
		else $error("DMA pointer load while stopped");

	a_init_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (init_lo_q <= INIT_END))
		else $error("free ring start range marker out of range");
`endif

endmodule

// ----- test/tb_dma_block_buffer_manager_unit.sv -----
// ----------------------------------------------------------------------------
// tb_dma_block_buffer_manager_unit: self-checking bench for the buffer manager
// A table of directed requests covers the idle state, start and restart,
// starvation of the DMA, undefined request codes and out-of-range releases.
// Then about 850 random requests follow, most of them shaped like normal
// traffic: block_done, pop, and release of the blocks that were popped.
// Every result is compared field by field with its table entry or with a
// behavioral model of the pool, while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_dma_block_buffer_manager_unit;
	import dbbm_pkg::*;

	localparam int POOL         = BUFFERS_DEF;
	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_LIMIT  = 2000;

	// Request codes that the block must treat as no-ops.
	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	typedef struct packed {
		logic        acc;
		logic [2:0]  blk;
		logic        seen;
		logic [31:0] total;
		logic [2:0]  cur;
		logic [2:0]  nxt;
		logic        nv;
		logic        stall;
		logic        run;
		logic        ld_cur;
		logic        ld_nxt;
	} pool_status_t;

	typedef struct packed {
		logic [2:0]   kind;
		logic [7:0]   idx;
		logic         typed;
		pool_status_t want;
	} step_row_t;

	localparam pool_status_t IDLE_STATE  = '{1'b0, 3'd0, 1'b0, 32'd0, 3'd0, 3'd1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam pool_status_t START_FRESH = '{1'b1, 3'd0, 1'b0, 32'd0, 3'd0, 3'd1,
		1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
	localparam pool_status_t START_HELD  = '{1'b1, 3'd0, 1'b0, 32'd0, 3'd0, 3'd1,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
	localparam pool_status_t RUN_QUIET   = '{1'b0, 3'd0, 1'b0, 32'd0, 3'd0, 3'd1,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

	localparam step_row_t DIRECTED_ROWS [25] = '{
		'{REQ_POP,      8'h00, 1'b1, IDLE_STATE},
		'{REQ_TAKE_OVR, 8'hFF, 1'b1, IDLE_STATE},
		'{REQ_STOP,     8'h55, 1'b1, IDLE_STATE},
		'{REQ_DONE,     8'hAA, 1'b1, IDLE_STATE},
		'{REQ_SPARE6,   8'h0F, 1'b1, IDLE_STATE},
		'{REQ_SPARE7,   8'hF0, 1'b1, IDLE_STATE},
		'{REQ_RELEASE,  8'hFF, 1'b1, IDLE_STATE},
		'{REQ_START,    8'h00, 1'b1, START_FRESH},
		'{REQ_START,    8'h80, 1'b1, START_HELD},
		'{REQ_DONE,     8'h01, 1'b0, '0},
		'{REQ_DONE,     8'h02, 1'b0, '0},
		'{REQ_DONE,     8'h04, 1'b0, '0},
		'{REQ_DONE,     8'h08, 1'b0, '0},
		'{REQ_DONE,     8'h10, 1'b0, '0},
		'{REQ_DONE,     8'h20, 1'b0, '0},
		'{REQ_DONE,     8'h40, 1'b0, '0},
		'{REQ_DONE,     8'h80, 1'b0, '0},
		'{REQ_DONE,     8'h00, 1'b0, '0},
		'{REQ_POP,      8'h00, 1'b0, '0},
		'{REQ_TAKE_OVR, 8'h00, 1'b0, '0},
		'{REQ_RELEASE,  8'h00, 1'b0, '0},
		'{REQ_STOP,     8'h00, 1'b0, '0},
		'{REQ_RELEASE,  8'h03, 1'b0, '0},
		'{REQ_START,    8'h00, 1'b1, START_FRESH},
		'{REQ_RELEASE,  8'h08, 1'b1, RUN_QUIET}
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        req_valid     = 1'b0;
	logic        req_ready;
	logic [2:0]  req_type      = REQ_STOP;
	logic [7:0]  release_index = 8'd0;
	logic        rsp_valid;
	logic        rsp_ready     = 1'b0;
	logic        accepted;
	logic [2:0]  block_index;
	logic        overrun_seen;
	logic [31:0] overrun_total;
	logic [2:0]  current_buffer;
	logic [2:0]  next_buffer;
	logic        next_valid;
	logic        fill_stalled;
	logic        is_running;
	logic        load_current;
	logic        load_next;

	dma_block_buffer_manager_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_type       (req_type),
		.release_index  (release_index),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.accepted       (accepted),
		.block_index    (block_index),
		.overrun_seen   (overrun_seen),
		.overrun_total  (overrun_total),
		.current_buffer (current_buffer),
		.next_buffer    (next_buffer),
		.next_valid     (next_valid),
		.fill_stalled   (fill_stalled),
		.is_running     (is_running),
		.load_current   (load_current),
		.load_next      (load_next)
	);

	// Model of the pool.
	int          done_ring [POOL];
	int          free_ring [POOL];
	int          done_wr = 0;
	int          done_rd = 0;
	int          free_wr = 0;
	int          free_rd = 0;
	int          cur_blk = 0;
	int          nxt_blk = 1;
	bit          nxt_held = 1'b0;
	bit          starved = 1'b0;
	bit          running = 1'b0;
	bit          ovr_sticky = 1'b0;
	logic [31:0] ovr_events = 32'd0;
	bit          reload_cur;
	bit          reload_nxt;

	pool_status_t pending_status [$];
	int           popped_blocks [$];
	int           mismatches = 0;
	int           n_checked = 0;
	int           n_req = 0;
	int           n_done_req = 0;
	int           n_release = 0;
	int           n_start = 0;
	int           n_pop_hit = 0;
	logic [31:0]  peak_overruns = 32'd0;

	function automatic bit free_put(int b);
		if ((free_wr + 1) % POOL == free_rd)
			return 1'b0;
		free_ring[free_wr] = b;
		free_wr = (free_wr + 1) % POOL;
		return 1'b1;
	endfunction

	function automatic bit free_get(output int b);
		if (free_wr == free_rd)
			return 1'b0;
		b = free_ring[free_rd];
		free_rd = (free_rd + 1) % POOL;
		return 1'b1;
	endfunction

	function automatic void count_overrun();
		ovr_sticky = 1'b1;
		if (ovr_events != OVR_MAX)
			ovr_events++;
	endfunction

	// Gives the DMA a current buffer if it is starved, then a next buffer.
	function automatic void refill_dma();
		int b;
		if (!running)
			return;
		if (starved) begin
			if (!free_get(b))
				return;
			cur_blk = b;
			starved = 1'b0;
			reload_cur = 1'b1;
		end
		if (!nxt_held && free_get(b)) begin
			nxt_blk = b;
			nxt_held = 1'b1;
			reload_nxt = 1'b1;
		end
	endfunction

	function automatic pool_status_t apply_request(logic [2:0] kind, logic [7:0] idx);
		pool_status_t s;
		int finished;
		bit ovr;
		bit queued;
		s = '0;
		reload_cur = 1'b0;
		reload_nxt = 1'b0;
		case (kind)
			REQ_START: begin
				s.acc = 1'b1;
				if (!running) begin
					ovr_sticky = 1'b0;
					ovr_events = 32'd0;
					running = 1'b1;
					cur_blk = 0;
					nxt_blk = 1;
					nxt_held = 1'b1;
					starved = 1'b0;
					done_wr = 0;
					done_rd = 0;
					free_wr = 0;
					free_rd = 0;
					for (int i = 2; i < POOL; i++)
						void'(free_put(i));
					reload_cur = 1'b1;
					reload_nxt = 1'b1;
				end
			end
			REQ_STOP: running = 1'b0;
			REQ_DONE: begin
				if (running && !starved) begin
					finished = cur_blk;
					ovr = 1'b0;
					if (nxt_held) begin
						cur_blk = nxt_blk;
						nxt_held = 1'b0;
					end else begin
						starved = 1'b1;
						ovr = 1'b1;
					end
					// A full completed ring keeps the block in the DMA instead.
					if ((done_wr + 1) % POOL == done_rd) begin
						ovr = 1'b1;
						if (starved) begin
							cur_blk = finished;
							starved = 1'b0;
							reload_cur = 1'b1;
						end else if (!nxt_held) begin
							nxt_blk = finished;
							nxt_held = 1'b1;
							reload_nxt = 1'b1;
						end
					end else begin
						done_ring[done_wr] = finished;
						done_wr = (done_wr + 1) % POOL;
					end
					if (ovr)
						count_overrun();
					refill_dma();
				end
			end
			REQ_POP: begin
				if (done_wr != done_rd) begin
					s.blk = 3'(done_ring[done_rd]);
					done_rd = (done_rd + 1) % POOL;
					s.acc = 1'b1;
				end
			end
			REQ_RELEASE: begin
				if (idx < POOL) begin
					queued = free_put(int'(idx));
					refill_dma();
					if (!queued)
						count_overrun();
				end
			end
			REQ_TAKE_OVR: begin
				s.seen = ovr_sticky;
				ovr_sticky = 1'b0;
			end
			default: ;
		endcase
		s.total  = ovr_events;
		s.cur    = 3'(cur_blk);
		s.nxt    = 3'(nxt_blk);
		s.nv     = nxt_held;
		s.stall  = starved;
		s.run    = running;
		s.ld_cur = reload_cur;
		s.ld_nxt = reload_nxt;
		return s;
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got)
			flag_error($sformatf("result %0d, %s: expected %0h, got %0h",
				n_checked, name, want, got));
	endfunction

	// Called at a rising edge; returns at the edge where the request transaction
	// completes, with valid still high.
	task automatic push_req(input logic [2:0] kind, input logic [7:0] idx, input logic typed,
			input pool_status_t typed_status, input int gap);
		pool_status_t predicted;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		req_type      <= kind;
		release_index <= idx;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = apply_request(kind, idx);
		pending_status.push_back(typed ? typed_status : predicted);
		n_req++;
		if (predicted.total > peak_overruns)
			peak_overruns = predicted.total;
		case (kind)
			REQ_DONE: n_done_req++;
			REQ_RELEASE: n_release++;
			REQ_START: begin
				n_start++;
				if (predicted.ld_cur)
					popped_blocks.delete();
			end
			REQ_POP: begin
				if (predicted.acc) begin
					n_pop_hit++;
					popped_blocks.push_back(int'(predicted.blk));
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Result side: random stalls before each transaction, with calm stretches.
	initial begin
		pool_status_t want;
		pool_status_t got;
		int stall;
		bit rx_calm;
		rx_calm = 1'b0;
		wait (arst_n);
		forever begin
			if (n_checked % 60 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			stall = rx_calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			got = '{accepted, block_index, overrun_seen, overrun_total, current_buffer,
				next_buffer, next_valid, fill_stalled, is_running, load_current, load_next};
			if (pending_status.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected", n_checked));
			end else begin
				want = pending_status.pop_front();
				compare_field("accepted", want.acc, got.acc);
				compare_field("block_index", want.blk, got.blk);
				compare_field("overrun_seen", want.seen, got.seen);
				compare_field("overrun_total", want.total, got.total);
				compare_field("current_buffer", want.cur, got.cur);
				compare_field("next_buffer", want.nxt, got.nxt);
				compare_field("next_valid", want.nv, got.nv);
				compare_field("fill_stalled", want.stall, got.stall);
				compare_field("is_running", want.run, got.run);
				compare_field("load_current", want.ld_cur, got.ld_cur);
				compare_field("load_next", want.ld_nxt, got.ld_nxt);
			end
			n_checked++;
		end
	end

	initial begin
		logic [2:0] kind;
		logic [7:0] idx;
		int pick;
		int gap;
		bit tx_calm;
		tx_calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r])
			push_req(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].want, $urandom_range(0, 19));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			// Halfway through, let the block drain completely before going on.
			if (n == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_status.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			idx  = 8'($urandom_range(0, 255));
			if (pick < 30) begin
				kind = REQ_DONE;
			end else if (pick < 52) begin
				kind = REQ_POP;
			end else if (pick < 74) begin
				// Mostly hand back blocks that software actually popped.
				kind = REQ_RELEASE;
				if (popped_blocks.size() != 0 && $urandom_range(0, 9) < 7)
					idx = 8'(popped_blocks.pop_front());
				else if ($urandom_range(0, 1) == 1)
					idx = 8'($urandom_range(0, POOL - 1));
			end else if (pick < 82) begin
				kind = REQ_TAKE_OVR;
			end else if (pick < 88) begin
				kind = REQ_START;
			end else if (pick < 94) begin
				kind = REQ_STOP;
			end else if (pick < 97) begin
				kind = ($urandom_range(0, 1) == 1) ? REQ_SPARE6 : REQ_SPARE7;
			end else begin
				kind = 3'($urandom_range(0, 7));
			end
			gap = tx_calm ? 0 : $urandom_range(0, 19);
			push_req(kind, idx, 1'b0, '0, gap);
		end
		req_valid <= 1'b0;

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests: %0d block_done, %0d releases, %0d starts,",
			n_req, n_done_req, n_release, n_start);
		$display("%0d pops with a block, %0d results compared, highest overrun count %0d.",
			n_pop_hit, n_checked, peak_overruns);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
